// ===== src/tdl_pkg.sv =====
// ----------------------------------------------------------------------------
// tdl_pkg
// shared types, register indexes and small tables for the trigger block
// ----------------------------------------------------------------------------
`default_nettype none

package tdl_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_R2_DEAD_ZONE    = 3'd0;
    localparam logic [2:0] REG_L2_DEAD_ZONE    = 3'd1;
    localparam logic [2:0] REG_R2_MODE         = 3'd2;
    localparam logic [2:0] REG_L2_MODE         = 3'd3;
    localparam logic [2:0] REG_R2_BOUNDARY     = 3'd4;
    localparam logic [2:0] REG_L2_BOUNDARY     = 3'd5;
    localparam logic [2:0] REG_R2_STAGE_BUTTON = 3'd6;
    localparam logic [2:0] REG_L2_STAGE_BUTTON = 3'd7;

    // axis mode codes (mode bits 1:0) and release-click flag (mode bit 2)
    localparam logic [1:0] AXIS_DISABLED = 2'd0;
    localparam logic [1:0] AXIS_RESCALE  = 2'd2;

    // click bits in the misc button byte
    localparam logic [7:0] CLICK_R2 = 8'h08;
    localparam logic [7:0] CLICK_L2 = 8'h04;

    // stage button codes
    localparam logic [3:0] BTN_SQUARE   = 4'd1;
    localparam logic [3:0] BTN_CROSS    = 4'd2;
    localparam logic [3:0] BTN_CIRCLE   = 4'd3;
    localparam logic [3:0] BTN_TRIANGLE = 4'd4;
    localparam logic [3:0] BTN_L1       = 4'd5;
    localparam logic [3:0] BTN_R1       = 4'd6;
    localparam logic [3:0] BTN_L3       = 4'd7;
    localparam logic [3:0] BTN_R3       = 4'd8;
    localparam logic [3:0] BTN_L2       = 4'd9;
    localparam logic [3:0] BTN_R2       = 4'd10;

    // trigger select
    localparam logic SEL_R2 = 1'b0;
    localparam logic SEL_L2 = 1'b1;

    localparam logic [2:0] DIV_LAST = 3'd7;

    typedef struct packed {
        logic [7:0] l2_value;
        logic [7:0] r2_value;
        logic [7:0] face_buttons;
        logic [7:0] misc_buttons;
    } tdl_in_t;

    typedef struct packed {
        logic [7:0] l2_out;
        logic [7:0] r2_out;
        logic [7:0] face_buttons_out;
        logic [7:0] misc_buttons_out;
        logic       r2_stage_fired;
        logic       l2_stage_fired;
    } tdl_out_t;

    typedef struct packed {
        logic in_load;
        logic div_start;
        logic div_step;
        logic div_store;
        logic out_load;
        logic sel;
    } tdl_cmd_t;

    typedef struct packed {
        logic [7:0] face_set;
        logic [7:0] misc_set;
        logic       force_l2;
        logic       force_r2;
    } tdl_press_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_STORE,
        ST_FINISH
    } tdl_state_t;

    // dead zone threshold, step*51/2, steps above ten clamp to ten
    function automatic logic [7:0] dz_threshold(input logic [3:0] dz);
        logic [7:0] thr;
        unique case (dz)
            4'd0:    thr = 8'd0;
            4'd1:    thr = 8'd25;
            4'd2:    thr = 8'd51;
            4'd3:    thr = 8'd76;
            4'd4:    thr = 8'd102;
            4'd5:    thr = 8'd127;
            4'd6:    thr = 8'd153;
            4'd7:    thr = 8'd178;
            4'd8:    thr = 8'd204;
            4'd9:    thr = 8'd229;
            default: thr = 8'd255;
        endcase
        return thr;
    endfunction

    function automatic tdl_press_t press_of(input logic [3:0] btn);
        tdl_press_t p;
        p = '0;
        unique case (btn)
            BTN_SQUARE:   p.face_set = 8'h10;
            BTN_CROSS:    p.face_set = 8'h20;
            BTN_CIRCLE:   p.face_set = 8'h40;
            BTN_TRIANGLE: p.face_set = 8'h80;
            BTN_L1:       p.misc_set = 8'h01;
            BTN_R1:       p.misc_set = 8'h02;
            BTN_L3:       p.misc_set = 8'h40;
            BTN_R3:       p.misc_set = 8'h80;
            BTN_L2:
            begin
                p.misc_set = CLICK_L2;
                p.force_l2 = 1'b1;
            end
            BTN_R2:
            begin
                p.misc_set = CLICK_R2;
                p.force_r2 = 1'b1;
            end
            default:      p = '0;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

// ===== src/tdl_shape.sv =====
// ----------------------------------------------------------------------------
// tdl_shape
// per-trigger dead zone, rescale select and hysteresis latch decision
// ----------------------------------------------------------------------------
`default_nettype none

module tdl_shape #(
    parameter int HYSTERESIS = 8
) (
    input  wire logic [7:0] raw,
    input  wire logic [3:0] dead_zone,
    input  wire logic [2:0] mode,
    input  wire logic [7:0] boundary,
    input  wire logic       latch,
    input  wire logic [7:0] scaled,
    output logic      [7:0] axis,
    output logic            clear_click,
    output logic            latch_next,
    output logic            fired
);
    import tdl_pkg::*;

    localparam logic [8:0] HYST_W = 9'(HYSTERESIS);

    logic [7:0] thr;
    logic       in_dead;
    logic       stage_on;
    logic [8:0] rel;

    always_comb
    begin
        thr      = dz_threshold(dead_zone);
        in_dead  = (dead_zone != 4'd0) && (raw < thr);
        stage_on = (mode[1:0] != AXIS_DISABLED) && (boundary != 8'd0);
        rel      = ({1'b0, boundary} > HYST_W) ? ({1'b0, boundary} - HYST_W) : 9'd1;

        axis = in_dead ? 8'd0 : raw;
        if (stage_on && (mode[1:0] == AXIS_RESCALE) && (boundary > thr))
        begin
            axis = scaled;
        end

        if (!stage_on)
        begin
            latch_next = 1'b0;
        end
        else if (latch)
        begin
            latch_next = !({1'b0, raw} < rel);
        end
        else
        begin
            latch_next = (raw >= boundary);
        end

        fired       = latch_next;
        clear_click = in_dead || (latch_next && mode[2]);
    end

endmodule

`default_nettype wire

// ===== src/tdl_ctrl.sv =====
// ----------------------------------------------------------------------------
// tdl_ctrl
// sequencer: input capture, two serial divisions, result hand-off
// ----------------------------------------------------------------------------
`default_nettype none

module tdl_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output tdl_pkg::tdl_cmd_t    cmd
);
    import tdl_pkg::*;

    tdl_state_t state_reg, state_next;
    logic       sel_reg, sel_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_LOAD;
                    sel_next   = SEL_R2;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_DIV;
                cnt_next   = '0;
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE:
            begin
                if (sel_reg == SEL_R2)
                begin
                    sel_next   = SEL_L2;
                    state_next = ST_LOAD;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd           = '0;
        cmd.sel       = sel_reg;
        cmd.in_load   = (state_reg == ST_IDLE) && in_valid;
        cmd.div_start = (state_reg == ST_LOAD);
        cmd.div_step  = (state_reg == ST_DIV);
        cmd.div_store = (state_reg == ST_STORE);
        cmd.out_load  = (state_reg == ST_FINISH) && out_free;

        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sel_reg       <= SEL_R2;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/tdl_datapath.sv =====
// ----------------------------------------------------------------------------
// tdl_datapath
// config registers, latches, shared serial divider and result register
// ----------------------------------------------------------------------------
`default_nettype none

module tdl_datapath #(
    parameter int HYSTERESIS = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire tdl_pkg::tdl_cmd_t cmd,
    input  wire tdl_pkg::tdl_in_t  in_data,
    input  wire logic              cfg_we,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [7:0]        cfg_wdata,
    output tdl_pkg::tdl_out_t      out_data
);
    import tdl_pkg::*;

    // config
    logic [3:0] r2_dz_reg, l2_dz_reg;
    logic [2:0] r2_mode_reg, l2_mode_reg;
    logic [7:0] r2_pos_reg, l2_pos_reg;
    logic [3:0] r2_btn_reg, l2_btn_reg;
    logic       r2_latch_reg, l2_latch_reg;
    logic       r2_latch_next, l2_latch_next;

    tdl_in_t    in_reg;
    tdl_out_t   out_reg, out_next;

    // divider
    logic [7:0] rem_reg, num_reg, quo_reg, div_reg;
    logic       sat_reg;
    logic [7:0] r2_scaled_reg, l2_scaled_reg;

    logic [7:0]  d_raw, d_thr, d_pos, d_v, d_div;
    logic [15:0] d_num;
    logic [8:0]  d_trial;
    logic        d_ge;

    always_comb
    begin
        d_raw   = (cmd.sel == SEL_L2) ? in_reg.l2_value : in_reg.r2_value;
        d_thr   = dz_threshold((cmd.sel == SEL_L2) ? l2_dz_reg : r2_dz_reg);
        d_pos   = (cmd.sel == SEL_L2) ? l2_pos_reg : r2_pos_reg;
        d_v     = (d_raw > d_thr) ? (d_raw - d_thr) : 8'd0;
        d_div   = d_pos - d_thr;
        // v*255 as v*256 - v
        d_num   = {d_v, 8'd0} - {8'd0, d_v};
        d_trial = {rem_reg, num_reg[7]};
        d_ge    = (d_trial >= {1'b0, div_reg});
    end

    always_ff @(posedge clk)
    begin
        if (cmd.in_load)
        begin
            in_reg <= in_data;
        end
        if (cmd.div_start)
        begin
            rem_reg <= d_num[15:8];
            num_reg <= d_num[7:0];
            div_reg <= d_div;
            sat_reg <= (d_v >= d_div);
            quo_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= d_ge ? 8'(d_trial - {1'b0, div_reg}) : d_trial[7:0];
            num_reg <= {num_reg[6:0], 1'b0};
            quo_reg <= {quo_reg[6:0], d_ge};
        end
        if (cmd.div_store)
        begin
            if (cmd.sel == SEL_L2)
            begin
                l2_scaled_reg <= sat_reg ? 8'd255 : quo_reg;
            end
            else
            begin
                r2_scaled_reg <= sat_reg ? 8'd255 : quo_reg;
            end
        end
        if (cmd.out_load)
        begin
            out_reg <= out_next;
        end
    end

    // trigger shaping
    logic [7:0] r2_axis, l2_axis;
    logic       r2_clr, l2_clr, r2_fired, l2_fired;

    tdl_shape #(.HYSTERESIS(HYSTERESIS)) u_shape_r2 (
        .raw         (in_reg.r2_value),
        .dead_zone   (r2_dz_reg),
        .mode        (r2_mode_reg),
        .boundary    (r2_pos_reg),
        .latch       (r2_latch_reg),
        .scaled      (r2_scaled_reg),
        .axis        (r2_axis),
        .clear_click (r2_clr),
        .latch_next  (r2_latch_next),
        .fired       (r2_fired)
    );

    tdl_shape #(.HYSTERESIS(HYSTERESIS)) u_shape_l2 (
        .raw         (in_reg.l2_value),
        .dead_zone   (l2_dz_reg),
        .mode        (l2_mode_reg),
        .boundary    (l2_pos_reg),
        .latch       (l2_latch_reg),
        .scaled      (l2_scaled_reg),
        .axis        (l2_axis),
        .clear_click (l2_clr),
        .latch_next  (l2_latch_next),
        .fired       (l2_fired)
    );

    tdl_press_t r2_press, l2_press;
    logic [7:0] misc_shaped;

    always_comb
    begin
        r2_press = r2_fired ? press_of(r2_btn_reg) : '0;
        l2_press = l2_fired ? press_of(l2_btn_reg) : '0;

        misc_shaped = in_reg.misc_buttons
                      & ~(r2_clr ? CLICK_R2 : 8'd0)
                      & ~(l2_clr ? CLICK_L2 : 8'd0);

        out_next.r2_out = (r2_press.force_r2 || l2_press.force_r2) ? 8'd255 : r2_axis;
        out_next.l2_out = (r2_press.force_l2 || l2_press.force_l2) ? 8'd255 : l2_axis;
        out_next.face_buttons_out = in_reg.face_buttons | r2_press.face_set
                                    | l2_press.face_set;
        out_next.misc_buttons_out = misc_shaped | r2_press.misc_set | l2_press.misc_set;
        out_next.r2_stage_fired   = r2_fired;
        out_next.l2_stage_fired   = l2_fired;
    end

    assign out_data = out_reg;

    // config writes and latch state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r2_dz_reg    <= '0;
            l2_dz_reg    <= '0;
            r2_mode_reg  <= '0;
            l2_mode_reg  <= '0;
            r2_pos_reg   <= '0;
            l2_pos_reg   <= '0;
            r2_btn_reg   <= '0;
            l2_btn_reg   <= '0;
            r2_latch_reg <= 1'b0;
            l2_latch_reg <= 1'b0;
        end
        else
        begin
            if (cmd.out_load)
            begin
                r2_latch_reg <= r2_latch_next;
                l2_latch_reg <= l2_latch_next;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_R2_DEAD_ZONE: r2_dz_reg <= cfg_wdata[3:0];
                    REG_L2_DEAD_ZONE: l2_dz_reg <= cfg_wdata[3:0];
                    REG_R2_MODE:
                    begin
                        if (cfg_wdata[2:0] != r2_mode_reg)
                        begin
                            r2_latch_reg <= 1'b0;
                        end
                        r2_mode_reg <= cfg_wdata[2:0];
                    end
                    REG_L2_MODE:
                    begin
                        if (cfg_wdata[2:0] != l2_mode_reg)
                        begin
                            l2_latch_reg <= 1'b0;
                        end
                        l2_mode_reg <= cfg_wdata[2:0];
                    end
                    REG_R2_BOUNDARY:
                    begin
                        if (cfg_wdata != r2_pos_reg)
                        begin
                            r2_latch_reg <= 1'b0;
                        end
                        r2_pos_reg <= cfg_wdata;
                    end
                    REG_L2_BOUNDARY:
                    begin
                        if (cfg_wdata != l2_pos_reg)
                        begin
                            l2_latch_reg <= 1'b0;
                        end
                        l2_pos_reg <= cfg_wdata;
                    end
                    REG_R2_STAGE_BUTTON: r2_btn_reg <= cfg_wdata[3:0];
                    REG_L2_STAGE_BUTTON: l2_btn_reg <= cfg_wdata[3:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/trigger_deadzone_two_stage_latch.sv =====
// ----------------------------------------------------------------------------
// trigger_deadzone_two_stage_latch
// two-stage analog trigger shaping for one gamepad report per item
// ----------------------------------------------------------------------------
//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  in      | in_valid, in_ready, in_data      | in
//  out     | out_valid, out_ready, out_data   | out
//  cfg     | cfg_we, cfg_index, cfg_wdata     | in
//
//  for each item the report is captured at the accept edge, then per trigger
//  (R2 first, then L2) a setup state, 8 steps of the shared bit-serial
//  divider and a store state, then a finish state that loads the result
//  register and raises out_valid
//  no new item is taken until the current one has left the finish state
//  reset (rst_n low) clears the sequencer, the latches and the config registers
//  a waiting result does not block the next item; only the finish state holds
//  while the result register is still full
// ----------------------------------------------------------------------------
`default_nettype none

module trigger_deadzone_two_stage_latch #(
    parameter int HYSTERESIS = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    // input item channel
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire tdl_pkg::tdl_in_t  in_data,
    // result item channel
    output logic                   out_valid,
    input  wire logic              out_ready,
    output tdl_pkg::tdl_out_t      out_data,
    // configuration write port
    input  wire logic              cfg_we,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [7:0]        cfg_wdata
);
    import tdl_pkg::*;

    // command bundle from the sequencer to the datapath
    tdl_cmd_t cmd;

    // sequencer: owns both handshakes and the divider step count
    tdl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // datapath: config, latches, divider (r2 first, then l2) and result register
    tdl_datapath #(.HYSTERESIS(HYSTERESIS)) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

// ===== src/tdl_checker.sv =====
// ----------------------------------------------------------------------------
// tdl_checker
// port-level checks on the trigger block, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module tdl_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire tdl_pkg::tdl_out_t out_data
);
    import tdl_pkg::*;

    // stalled result holds
    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data);
    endproperty
    a_out_hold: assert property (p_out_hold) else $error("result changed while stalled");

    // block is busy right after taking an item
    property p_busy_after_accept;
        @(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready;
    endproperty
    a_busy_after_accept: assert property (p_busy_after_accept)
        else $error("ready right after accept");

    // a new result only appears at the end of a busy period
    property p_result_after_work;
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready);
    endproperty
    a_result_after_work: assert property (p_result_after_work)
        else $error("result without work");

    // a result never appears in the cycle right after an accept
    property p_no_instant_result;
        @(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> !out_valid;
    endproperty
    a_no_instant_result: assert property (p_no_instant_result)
        else $error("result too early");

endmodule

bind trigger_deadzone_two_stage_latch tdl_checker u_tdl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the two-stage trigger shaper: a behavioral predictor
// follows every accepted report, and each result is compared field by field
// with the oldest prediction; directed cases come first, then random reports
// under many register settings with random idling on both channels
// ----------------------------------------------------------------------------
module tb;
    import tdl_pkg::*;

    localparam int HYST              = 8;
    localparam int STALL_PCT         = 21;
    localparam int WATCHDOG_LIMIT    = 3000;
    localparam int SETTLE_CYCLES     = 30;
    localparam int RANDOM_PHASES     = 22;
    localparam int REPORTS_PER_PHASE = 25;
    localparam int QUIET_PHASE       = 6;

    // axis codes not named in the package, and the release-click mode bit
    localparam logic [1:0] AXIS_LATCH     = 2'd1;
    localparam logic [1:0] AXIS_LATCH_ALT = 2'd3;
    localparam logic       CLICK_KEEP     = 1'b0;
    localparam logic       CLICK_DROP     = 1'b1;
    localparam int         MODE_DROP_BIT  = 2;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    tdl_in_t    in_data   = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    tdl_out_t   out_data;
    logic       cfg_we    = 1'b0;
    logic [2:0] cfg_index = REG_R2_DEAD_ZONE;
    logic [7:0] cfg_wdata = '0;

    // predictor state: register copies and the two hysteresis latches
    logic [7:0] reg_mirror [8];
    logic       r2_held = 1'b0;
    logic       l2_held = 1'b0;

    // predicted results, oldest first
    tdl_out_t   expected_reports[$];
    tdl_out_t   oldest_report;

    bit         no_idling = 1'b0;
    int         fail_count      = 0;
    int         reports_sent    = 0;
    int         reports_checked = 0;
    int         r2_fires        = 0;
    int         l2_fires        = 0;
    int         settings_used   = 0;
    int         stuck_cycles    = 0;

    trigger_deadzone_two_stage_latch #(
        .HYSTERESIS(HYST)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // one trigger: dead zone, optional rescale, hysteresis latch, click drop
    // returns 1 when the stage is latched after this report
    function automatic logic shape_axis(
        input  logic [7:0] raw,
        input  logic [7:0] click,
        input  logic [3:0] dz,
        input  logic [2:0] mode,
        input  logic [7:0] pos,
        output logic [7:0] axis,
        inout  logic [7:0] misc,
        inout  logic       held
    );
        int step;
        int thr;
        int span;
        int scaled;
        int release_at;
        step = (dz > 4'd10) ? 10 : int'(dz);
        thr  = step * 51 / 2;
        axis = raw;
        if (step != 0 && int'(raw) < thr)
        begin
            axis = '0;
            misc = misc & ~click;
        end
        // axis off or no boundary: stage disabled, latch dropped
        if (mode[1:0] == AXIS_DISABLED || pos == 8'd0)
        begin
            held = 1'b0;
            return 1'b0;
        end
        // stretch dead zone..boundary over the full range, only if the span is positive
        if (mode[1:0] == AXIS_RESCALE && int'(pos) > thr)
        begin
            span   = (int'(raw) <= thr) ? 0 : int'(raw) - thr;
            scaled = span * 255 / (int'(pos) - thr);
            axis   = (scaled > 255) ? 8'hFF : scaled[7:0];
        end
        release_at = (int'(pos) > HYST) ? int'(pos) - HYST : 1;
        if (held)
        begin
            if (int'(raw) < release_at)
                held = 1'b0;
        end
        else if (raw >= pos)
        begin
            held = 1'b1;
        end
        if (held && mode[MODE_DROP_BIT])
            misc = misc & ~click;
        return held;
    endfunction

    // stage-two press; trigger targets also force their axis to full
    function automatic void press_stage(
        input  logic [3:0] btn,
        inout  logic [7:0] face,
        inout  logic [7:0] misc,
        inout  logic [7:0] l2_axis,
        inout  logic [7:0] r2_axis
    );
        case (btn)
            BTN_SQUARE:   face = face | 8'h10;
            BTN_CROSS:    face = face | 8'h20;
            BTN_CIRCLE:   face = face | 8'h40;
            BTN_TRIANGLE: face = face | 8'h80;
            BTN_L1:       misc = misc | 8'h01;
            BTN_R1:       misc = misc | 8'h02;
            BTN_L3:       misc = misc | 8'h40;
            BTN_R3:       misc = misc | 8'h80;
            BTN_L2:
            begin
                misc    = misc | CLICK_L2;
                l2_axis = 8'hFF;
            end
            BTN_R2:
            begin
                misc    = misc | CLICK_R2;
                r2_axis = 8'hFF;
            end
            default:      ;
        endcase
    endfunction

    // whole report: R2 then L2 from raw values, then presses, R2 first
    function automatic tdl_out_t shape_report(input tdl_in_t item);
        tdl_out_t   res;
        logic [7:0] face;
        logic [7:0] misc;
        logic [7:0] l2_axis;
        logic [7:0] r2_axis;
        logic       r2_fire;
        logic       l2_fire;
        face = item.face_buttons;
        misc = item.misc_buttons;
        r2_fire = shape_axis(item.r2_value, CLICK_R2, reg_mirror[REG_R2_DEAD_ZONE][3:0],
                             reg_mirror[REG_R2_MODE][2:0], reg_mirror[REG_R2_BOUNDARY],
                             r2_axis, misc, r2_held);
        l2_fire = shape_axis(item.l2_value, CLICK_L2, reg_mirror[REG_L2_DEAD_ZONE][3:0],
                             reg_mirror[REG_L2_MODE][2:0], reg_mirror[REG_L2_BOUNDARY],
                             l2_axis, misc, l2_held);
        if (r2_fire)
            press_stage(reg_mirror[REG_R2_STAGE_BUTTON][3:0], face, misc, l2_axis, r2_axis);
        if (l2_fire)
            press_stage(reg_mirror[REG_L2_STAGE_BUTTON][3:0], face, misc, l2_axis, r2_axis);
        res.l2_out           = l2_axis;
        res.r2_out           = r2_axis;
        res.face_buttons_out = face;
        res.misc_buttons_out = misc;
        res.r2_stage_fired   = r2_fire;
        res.l2_stage_fired   = l2_fire;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------

    // one register write, one cycle of cfg_we; mode and boundary writes
    // drop the latch only when the value really changes
    task automatic write_reg(input logic [2:0] index, input logic [7:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        if ((index == REG_R2_MODE || index == REG_R2_BOUNDARY) && value != reg_mirror[index])
            r2_held = 1'b0;
        if ((index == REG_L2_MODE || index == REG_L2_BOUNDARY) && value != reg_mirror[index])
            l2_held = 1'b0;
        reg_mirror[index] = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // full register set, in index order
    task automatic configure(
        input logic [3:0] dz_r,
        input logic [3:0] dz_l,
        input logic [2:0] mode_r,
        input logic [2:0] mode_l,
        input logic [7:0] pos_r,
        input logic [7:0] pos_l,
        input logic [3:0] btn_r,
        input logic [3:0] btn_l
    );
        write_reg(REG_R2_DEAD_ZONE, {4'd0, dz_r});
        write_reg(REG_L2_DEAD_ZONE, {4'd0, dz_l});
        write_reg(REG_R2_MODE, {5'd0, mode_r});
        write_reg(REG_L2_MODE, {5'd0, mode_l});
        write_reg(REG_R2_BOUNDARY, pos_r);
        write_reg(REG_L2_BOUNDARY, pos_l);
        write_reg(REG_R2_STAGE_BUTTON, {4'd0, btn_r});
        write_reg(REG_L2_STAGE_BUTTON, {4'd0, btn_l});
        settings_used++;
    endtask

    // present one report and hold it until accepted; valid stays high
    // on return so that back-to-back items need no extra edge
    task automatic send_report(
        input logic [7:0] l2_raw,
        input logic [7:0] r2_raw,
        input logic [7:0] face,
        input logic [7:0] misc
    );
        tdl_in_t item;
        item.l2_value     = l2_raw;
        item.r2_value     = r2_raw;
        item.face_buttons = face;
        item.misc_buttons = misc;
        @(negedge clk);
        while (!no_idling && $urandom_range(99) < STALL_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        // config is stable while items flow, so predict in send order
        expected_reports.push_back(shape_report(item));
        reports_sent++;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // drop valid, let every pending result come out, then a few spare cycles
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // receiver side stalls at random unless idling is switched off
    always @(negedge clk)
        out_ready <= no_idling || ($urandom_range(99) >= STALL_PCT);

    // ------------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------------

    task automatic compare_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_reports.size() == 0)
            begin
                $error("result item with no report pending");
                fail_count++;
            end
            else
            begin
                oldest_report = expected_reports.pop_front();
                compare_field("l2_out", oldest_report.l2_out, out_data.l2_out);
                compare_field("r2_out", oldest_report.r2_out, out_data.r2_out);
                compare_field("face_buttons_out", oldest_report.face_buttons_out,
                              out_data.face_buttons_out);
                compare_field("misc_buttons_out", oldest_report.misc_buttons_out,
                              out_data.misc_buttons_out);
                compare_field("r2_stage_fired", {7'd0, oldest_report.r2_stage_fired},
                              {7'd0, out_data.r2_stage_fired});
                compare_field("l2_stage_fired", {7'd0, oldest_report.l2_stage_fired},
                              {7'd0, out_data.l2_stage_fired});
                reports_checked++;
                if (oldest_report.r2_stage_fired)
                    r2_fires++;
                if (oldest_report.l2_stage_fired)
                    l2_fires++;
            end
        end
    end

    // watchdog: too long with nothing moving on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            stuck_cycles = 0;
        end
        else
        begin
            stuck_cycles++;
            if (stuck_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // registers at reset: both stages off, no dead zone, field extremes
    task automatic test_reset_defaults();
        send_report(8'h00, 8'h00, 8'h00, 8'h00);
        send_report(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        wait_idle();
    endtask

    // widest and narrowest dead zones, step above ten, axis off with a
    // boundary and boundary zero with the axis on
    task automatic test_dead_zone();
        configure(4'd10, 4'd15, {CLICK_KEEP, AXIS_DISABLED}, {CLICK_KEEP, AXIS_LATCH},
                  8'd200, 8'd0, BTN_R2, BTN_L2);
        send_report(8'd255, 8'd254, 8'h00, 8'hFF);
        send_report(8'd254, 8'd255, 8'h00, 8'hFF);
        wait_idle();
        configure(4'd1, 4'd1, {CLICK_KEEP, AXIS_DISABLED}, {CLICK_KEEP, AXIS_DISABLED},
                  8'd0, 8'd0, 4'd0, 4'd0);
        send_report(8'd24, 8'd25, 8'h00, 8'h0C);
        send_report(8'd25, 8'd24, 8'h00, 8'h0C);
        wait_idle();
    endtask

    // R2 rescales over a positive span; L2 boundary equals its threshold,
    // so no rescale there, and its latched stage drops the click bit
    task automatic test_rescale();
        configure(4'd4, 4'd4, {CLICK_KEEP, AXIS_RESCALE}, {CLICK_DROP, AXIS_RESCALE},
                  8'd200, 8'd102, 4'd0, 4'd0);
        send_report(8'd150, 8'd150, 8'h00, 8'hFF);
        send_report(8'd255, 8'd255, 8'h00, 8'hFF);
        send_report(8'd102, 8'd102, 8'h00, 8'hFF);
        send_report(8'd103, 8'd103, 8'h00, 8'hFF);
        wait_idle();
    endtask

    // engage, hold inside the band, release below it; L2 boundary is not
    // above the hysteresis so it only lets go at zero; same-value writes
    // keep the latch, changed writes drop it
    task automatic test_hysteresis();
        configure(4'd0, 4'd0, {CLICK_DROP, AXIS_LATCH}, {CLICK_KEEP, AXIS_LATCH_ALT},
                  8'd100, 8'd5, 4'd0, 4'd0);
        send_report(8'd4, 8'd99, 8'h00, 8'hFF);
        send_report(8'd5, 8'd100, 8'h00, 8'hFF);
        send_report(8'd1, 8'd92, 8'h00, 8'hFF);
        wait_idle();
        write_reg(REG_R2_BOUNDARY, 8'd100);
        write_reg(REG_L2_MODE, {5'd0, CLICK_KEEP, AXIS_LATCH_ALT});
        send_report(8'd3, 8'd95, 8'h00, 8'hFF);
        wait_idle();
        write_reg(REG_R2_BOUNDARY, 8'd101);
        write_reg(REG_L2_MODE, {5'd0, CLICK_DROP, AXIS_LATCH_ALT});
        send_report(8'd3, 8'd95, 8'h00, 8'hFF);
        send_report(8'd5, 8'd101, 8'h00, 8'hFF);
        send_report(8'd0, 8'd93, 8'h00, 8'hFF);
        send_report(8'd0, 8'd92, 8'h00, 8'hFF);
        wait_idle();
    endtask

    // both stages latched on any nonzero value; walk every button code,
    // including none and the codes above the last button
    task automatic test_stage_buttons();
        configure(4'd0, 4'd0, {CLICK_KEEP, AXIS_LATCH}, {CLICK_KEEP, AXIS_LATCH},
                  8'd1, 8'd1, 4'd0, 4'd1);
        for (int k = 0; k < 8; k++)
        begin
            write_reg(REG_R2_STAGE_BUTTON, 8'(2 * k));
            write_reg(REG_L2_STAGE_BUTTON, 8'(2 * k + 1));
            send_report(8'd40, 8'd60, 8'h00, 8'h00);
            wait_idle();
        end
    endtask

    function automatic logic [3:0] pick_dead_zone();
        if ($urandom_range(99) < 15)
            return 4'($urandom_range(15, 11));
        return 4'($urandom_range(10));
    endfunction

    // boundaries cluster on the corners of the hysteresis rule
    function automatic logic [7:0] pick_boundary();
        case ($urandom_range(7))
            0:       return 8'd0;
            1:       return 8'd1;
            2:       return 8'(HYST);
            3:       return 8'(HYST + 1);
            4:       return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // most raw values land near the boundary so the latch keeps toggling
    function automatic logic [7:0] near_boundary(input logic [7:0] pos);
        int v;
        if ($urandom_range(99) < 65)
        begin
            v = int'(pos) + int'($urandom_range(24)) - 12;
            if (v < 0)
                v = 0;
            if (v > 255)
                v = 255;
            return 8'(v);
        end
        return 8'($urandom_range(255));
    endfunction

    // random reports over many settings; first two phases are the extremes,
    // one phase runs with no idling on either side
    task automatic test_random();
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            no_idling = (phase == QUIET_PHASE);
            if (phase == 0)
                configure(4'd15, 4'd15, 3'd7, 3'd7, 8'd255, 8'd255, 4'd15, 4'd15);
            else if (phase == 1)
                configure(4'd0, 4'd0, {CLICK_KEEP, AXIS_LATCH_ALT}, {CLICK_DROP, AXIS_LATCH},
                          8'd1, 8'd1, BTN_R2, BTN_L2);
            else
                configure(pick_dead_zone(), pick_dead_zone(), 3'($urandom_range(7)),
                          3'($urandom_range(7)), pick_boundary(), pick_boundary(),
                          4'($urandom_range(15)), 4'($urandom_range(15)));
            for (int n = 0; n < REPORTS_PER_PHASE; n++)
                send_report(near_boundary(reg_mirror[REG_L2_BOUNDARY]),
                            near_boundary(reg_mirror[REG_R2_BOUNDARY]),
                            8'($urandom_range(255)), 8'($urandom_range(255)));
            wait_idle();
        end
        no_idling = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial
    begin
        for (int i = 0; i < 8; i++)
            reg_mirror[i] = 8'd0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_dead_zone();
        test_rescale();
        test_hysteresis();
        test_stage_buttons();
        test_random();

        // anything arriving now is a stray result and is flagged by the checker
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("%0d reports sent, %0d results checked, %0d register settings",
                 reports_sent, reports_checked, settings_used);
        $display("second stage fired: R2 %0d times, L2 %0d times", r2_fires, l2_fires);
        if (fail_count == 0 && expected_reports.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
src/tdl_pkg.sv
src/tdl_shape.sv
src/tdl_ctrl.sv
src/tdl_datapath.sv
src/trigger_deadzone_two_stage_latch.sv
src/tdl_checker.sv
tb/tb.sv
